// ----- hdl/rhht_pkg.sv -----
// Shared types and constants for the Robin Hood hash table.
`timescale 1ns / 1ps
package rhht_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_INVALID   = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    localparam logic [31:0] MIX_MULT = 32'h045d9f3b;
    localparam logic [8:0]  MAX_ENTRIES_RESET = 9'd192;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [8:0]  entry_total;
    } t_out_item;
endpackage

// ----- hdl/robin_hood_hash_table.sv -----
// Robin Hood hash table top level: hashing, probe, shift and delete sequencer.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                      payload
//  -------  ---------  -----------------------------  -----------------------
//  command  in         start & !busy = transfer       i_cmd  (op, key, value)
//  result   out        o_done strobe, one cycle       o_res  (status, value, total)
//  config   in         i_cfg_valid & o_cfg_ready      i_cfg_data (max_entries)
//
//  Hashing runs through S_H1 to S_H4 (two registered multiplies split in
//  partial products, final xor); each probed slot takes a memory read,
//  then compare/modify/write. A zero key skips hashing and answers
//  through S_DONE. Clear sweeps the slots one per cycle and holds busy
//  until its result. Reset runs the same sweep before the first command;
//  busy stays high meanwhile. Config writes are always taken.
//  The result strobe cannot be stalled by the receiver.
module robin_hood_hash_table #(
    parameter int SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rhht_pkg::t_in_item  i_cmd,
    output logic                o_done,
    output rhht_pkg::t_out_item o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [8:0]          i_cfg_data
);
    import rhht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_H1    = 11'b00000000100,
        S_H2    = 11'b00000001000,
        S_H3    = 11'b00000010000,
        S_H4    = 11'b00000100000,
        S_FRD   = 11'b00001000000,
        S_FCHK  = 11'b00010000000,
        S_PCHK  = 11'b00100000000,
        S_RCHK  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic          used;
        logic [31:0]   key;
        logic [31:0]   value;
        logic [AW-1:0] pdist;
    } t_slot;

    // slot memory, one read port registered, one write port
    t_slot       mem [SLOTS];
    t_slot       r_rd;

    t_state      r_state;
    t_in_item    r_cmd;
    logic [8:0]  r_max;
    logic [CW-1:0] r_count;
    logic [63:0] r_x;
    logic [63:0] r_pa, r_pb;
    logic [AW-1:0] r_idx, r_cur;
    logic [AW-1:0] r_d;
    logic [CW-1:0] r_n;
    t_slot       r_carry;
    logic [2:0]  r_status;
    logic [31:0] r_fv;
    logic        r_hpass;

    logic [AW-1:0] nxt;
    logic [31:0] limit;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign nxt         = r_idx + AW'(1);
    assign limit       = (32'(r_max) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(r_max);

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ENTRIES_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_count <= '0;
            r_idx   <= '0;
            r_n     <= '0;
            o_done  <= 1'b0;
            r_hpass <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    // sweep the slots one per cycle
                    mem[r_idx] <= '0;
                    r_idx <= nxt;
                    r_n   <= r_n + CW'(1);
                    if (r_n == CW'(SLOTS - 1)) begin
                        r_count <= '0;
                        r_state <= r_hpass ? S_DONE : S_IDLE;
                        r_status <= ST_CLEARED;
                        r_fv <= '0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_cmd;
                        r_fv  <= '0;
                        if (i_cmd.op == OP_CLEAR) begin
                            r_idx <= '0; r_n <= '0; r_hpass <= 1'b1;
                            r_state <= S_CLR;
                        end else if (i_cmd.key == 32'd0) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_DONE;
                        end else begin
                            r_x <= {32'd0, i_cmd.key ^ (i_cmd.key >> 16)};
                            r_state <= S_H1;
                        end
                    end
                end
                S_H1: begin
                    // split the 64x32 multiply into two 32-bit partial products
                    r_pa <= 64'(r_x[31:0] * MIX_MULT);
                    r_pb <= 64'(r_x[63:32] * MIX_MULT);
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_x <= (r_pa + {r_pb[31:0], 32'd0}) ^
                           ((r_pa + {r_pb[31:0], 32'd0}) >> 16);
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_pa <= 64'(r_x[31:0] * MIX_MULT);
                    r_pb <= 64'(r_x[63:32] * MIX_MULT);
                    r_state <= S_H4;
                end
                S_H4: begin
                    r_idx <= AW'((r_pa + {r_pb[31:0], 32'd0}) ^
                                 ((r_pa + {r_pb[31:0], 32'd0}) >> 16));
                    r_d <= '0;
                    r_n <= '0;
                    r_state <= S_FRD;
                end
                S_FRD: begin
                    // memory read in flight
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (!r_rd.used || r_d > r_rd.pdist || r_n == CW'(SLOTS)) begin
                        if (r_cmd.op == OP_INSERT) begin
                            if (32'(r_count) >= limit) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                // restart probe from home slot to place
                                r_idx <= r_idx - r_d;
                                r_carry <= '{used: 1'b1, key: r_cmd.key,
                                             value: r_cmd.value, pdist: '0};
                                r_n <= '0;
                                r_status <= ST_INSERTED;
                                r_state <= S_PCHK;
                                r_hpass <= 1'b0;
                            end
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_DONE;
                        end
                    end else if (r_rd.key == r_cmd.key) begin
                        case (r_cmd.op)
                            OP_INSERT: begin
                                mem[r_idx].value <= r_cmd.value;
                                r_status <= ST_UPDATED;
                                r_state <= S_DONE;
                            end
                            OP_LOOKUP: begin
                                r_fv <= r_rd.value;
                                r_status <= ST_FOUND;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_cur <= r_idx;
                                r_idx <= nxt;
                                r_n <= CW'(1);
                                r_status <= ST_REMOVED;
                                r_hpass <= 1'b0;
                                r_state <= S_RCHK;
                            end
                        endcase
                    end else begin
                        r_d <= r_d + AW'(1);
                        r_n <= r_n + CW'(1);
                        r_idx <= nxt;
                        r_state <= S_FRD;
                    end
                end
                S_PCHK: begin
                    // r_hpass: read of r_idx landed
                    r_hpass <= ~r_hpass;
                    if (r_hpass) begin
                        if (!r_rd.used) begin
                            mem[r_idx] <= r_carry;
                            r_count <= r_count + CW'(1);
                            r_state <= S_DONE;
                        end else begin
                            if (r_carry.pdist > r_rd.pdist) begin
                                mem[r_idx] <= r_carry;
                                r_carry <= '{used: 1'b1, key: r_rd.key, value: r_rd.value,
                                             pdist: r_rd.pdist + AW'(1)};
                            end else begin
                                r_carry.pdist <= r_carry.pdist + AW'(1);
                            end
                            r_idx <= nxt;
                        end
                    end
                end
                S_RCHK: begin
                    r_hpass <= ~r_hpass;
                    if (r_hpass) begin
                        if (!r_rd.used || r_rd.pdist == '0 || r_n == CW'(SLOTS)) begin
                            mem[r_cur].used <= 1'b0;
                            r_count <= r_count - CW'(1);
                            r_state <= S_DONE;
                        end else begin
                            mem[r_cur] <= '{used: 1'b1, key: r_rd.key, value: r_rd.value,
                                            pdist: r_rd.pdist - AW'(1)};
                            r_cur <= r_idx;
                            r_idx <= nxt;
                            r_n <= r_n + CW'(1);
                        end
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    r_hpass <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.status      = r_status;
    assign o_res.found_value = r_fv;
    assign o_res.entry_total = 9'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS)) else $error("entry count above table size");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("result strobe outside idle");
    a_fv_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_status != ST_FOUND |-> r_fv == '0)
        else $error("found value not zero");
endmodule
